FILE: hdl/indexed_linked_list_manager_core_macros.svh
// ----------------------------------------------------------------------------
// indexed_linked_list_manager_core_macros
// assertion shorthands for the list manager; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_MANAGER_CORE_MACROS_SVH
`define INDEXED_LINKED_LIST_MANAGER_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ILM_ASSERT_IMP(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("ilm assertion failed");

// next-cycle implication
`define ILM_ASSERT_NXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("ilm assertion failed");

`else

`define ILM_ASSERT_IMP(label, clk, rst, ante, cons)
`define ILM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/ilm_pkg.sv
// ----------------------------------------------------------------------------
// ilm_pkg
// shared types, codes and helpers of the indexed linked list manager
// ----------------------------------------------------------------------------
package ilm_pkg;

    localparam int ACT_W  = 3;
    localparam int LID_W  = 2;
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 9;
    localparam int WALK_W = 11;

    localparam logic [ACT_W-1:0] ACT_INIT    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FILL    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PULL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PREPEND = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FREE    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = 9'd511;

    // index of the last node a free walk may visit
    localparam logic [WALK_W-1:0] WALK_LAST = 11'd2001;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [LID_W-1:0]  list_id;
        logic [LID_W-1:0]  other_list;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_out;
        logic              list_empty;
        logic [LEN_W-1:0]  list_length;
    } out_item_t;

    function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] v);
        return (v < LEN_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic [LEN_W-1:0] len_dec(logic [LEN_W-1:0] v);
        return (v != '0) ? v - 1'b1 : v;
    endfunction

endpackage

FILE: hdl/ilm_chan_if.sv
// ----------------------------------------------------------------------------
// ilm_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface ilm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/indexed_linked_list_manager_core.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_manager_core - slot lists over a shared link ram
// one beat at a time; fill time grows with count and free time with nodes
// visited; the result becomes valid in the same cycle the next beat can be taken
// one link ram access per cycle sets free and fill time
// async active-low reset empties every list at once, link ram is not cleared
// ----------------------------------------------------------------------------
`include "indexed_linked_list_manager_core_macros.svh"

module indexed_linked_list_manager_core #(
    parameter int NUM_SLOTS = 256,
    parameter int NUM_LISTS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    ilm_chan_if.sink   cmd,
    ilm_chan_if.source res
);

    localparam int ADDR_W  = $clog2(NUM_SLOTS);
    localparam int PTR_W   = $clog2(NUM_SLOTS + 1);
    localparam int LIST_W  = $clog2(NUM_LISTS);
    localparam int ENTRY_W = 2 * PTR_W + ilm_pkg::LEN_W;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

    typedef struct packed {
        logic [PTR_W-1:0]          head;
        logic [PTR_W-1:0]          tail;
        logic [ilm_pkg::LEN_W-1:0] len;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LIST    = 9'b000000010,
        S_FILL    = 9'b000000100,
        S_PULL    = 9'b000001000,
        S_WALK    = 9'b000010000,
        S_DST     = 9'b000100000,
        S_APP     = 9'b001000000,
        S_APP_END = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    // control
    state_t                     state_reg, state_next;
    logic [NUM_LISTS-1:0]       list_vld_reg, list_vld_next;
    logic                       out_valid_reg, out_valid_next;

    // payload
    logic [ilm_pkg::ACT_W-1:0]  act_reg, act_next;
    logic [LIST_W-1:0]          lidx_reg, lidx_next;
    logic [LIST_W-1:0]          didx_reg, didx_next;
    logic [ilm_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [ilm_pkg::SLOT_W-1:0] sout_reg, sout_next;
    logic                       slot_bad_reg, slot_bad_next;
    logic                       dst_bad_reg, dst_bad_next;
    logic                       dst_same_reg, dst_same_next;
    logic [ilm_pkg::LEN_W-1:0]  fill_len_reg, fill_len_next;
    logic [ilm_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       rep_tgt_reg, rep_tgt_next;
    entry_t                     src_reg, src_next;
    entry_t                     tgt_reg, tgt_next;
    logic [PTR_W-1:0]           cur_reg, cur_next;
    logic [PTR_W-1:0]           prev_reg, prev_next;
    logic [ilm_pkg::WALK_W-1:0] walk_k_reg, walk_k_next;
    ilm_pkg::out_item_t         out_data_reg, out_data_next;

    // memories
    logic                       link_we;
    logic [ADDR_W-1:0]          link_waddr;
    logic [PTR_W-1:0]           link_wdata;
    logic [ADDR_W-1:0]          link_raddr;
    logic [PTR_W-1:0]           link_rdata;
    logic                       list_we;
    logic [LIST_W-1:0]          list_waddr;
    entry_t                     list_wdata;
    logic [LIST_W-1:0]          list_raddr;
    logic [ENTRY_W-1:0]         list_rdata;

    logic                       cmd_acc;
    logic [PTR_W-1:0]           slot_ptr;
    entry_t                     ent_rst;
    entry_t                     list_e;
    entry_t                     dst_e;
    entry_t                     rep_e;
    logic [ilm_pkg::LEN_W-1:0]  in_fill_len;

    ilm_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ilm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LISTS)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (ENTRY_W'(list_wdata)),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    assign slot_ptr = PTR_W'(slot_reg);
    assign ent_rst  = '{head: NIL, tail: NIL, len: '0};

    // a list never written reads as empty
    assign list_e = list_vld_reg[lidx_reg] ? entry_t'(list_rdata) : ent_rst;
    assign dst_e  = list_vld_reg[didx_reg] ? entry_t'(list_rdata) : ent_rst;
    assign rep_e  = rep_tgt_reg ? tgt_reg : src_reg;

    assign in_fill_len = (32'(cmd.data.count) > 32'(NUM_SLOTS)) ?
                         ilm_pkg::LEN_W'(NUM_SLOTS) : cmd.data.count;

    // walk reads chain straight off the previous read data
    assign list_raddr = (state_reg == S_WALK) ? didx_reg : LIST_W'(cmd.data.list_id);
    assign link_raddr = (state_reg == S_LIST) ? list_e.head[ADDR_W-1:0]
                                              : link_rdata[ADDR_W-1:0];

    always_comb
    begin
        entry_t           ent_v;
        logic [PTR_W-1:0] nxt_v;

        ent_v          = src_reg;
        nxt_v          = link_rdata;

        state_next     = state_reg;
        list_vld_next  = list_vld_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_data_next  = out_data_reg;

        act_next       = act_reg;
        lidx_next      = lidx_reg;
        didx_next      = didx_reg;
        slot_next      = slot_reg;
        sout_next      = sout_reg;
        slot_bad_next  = slot_bad_reg;
        dst_bad_next   = dst_bad_reg;
        dst_same_next  = dst_same_reg;
        fill_len_next  = fill_len_reg;
        status_next    = status_reg;
        rep_tgt_next   = rep_tgt_reg;
        src_next       = src_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        walk_k_next    = walk_k_reg;

        link_we        = 1'b0;
        link_waddr     = cur_reg[ADDR_W-1:0];
        link_wdata     = NIL;
        list_we        = 1'b0;
        list_waddr     = lidx_reg;
        list_wdata     = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    act_next      = cmd.data.action;
                    lidx_next     = LIST_W'(cmd.data.list_id);
                    didx_next     = LIST_W'(cmd.data.other_list);
                    slot_next     = cmd.data.slot;
                    sout_next     = cmd.data.slot;
                    slot_bad_next = 32'(cmd.data.slot) >= 32'(NUM_SLOTS);
                    dst_bad_next  = 32'(cmd.data.other_list) >= 32'(NUM_LISTS);
                    dst_same_next = cmd.data.other_list == cmd.data.list_id;
                    fill_len_next = in_fill_len;
                    status_next   = ilm_pkg::ST_OK;
                    rep_tgt_next  = 1'b0;
                    if (32'(cmd.data.list_id) >= 32'(NUM_LISTS))
                    begin
                        status_next = ilm_pkg::ST_EMPTY;
                        src_next    = ent_rst;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
            end

            S_LIST:
            begin
                src_next   = list_e;
                state_next = S_DONE;
                case (act_reg)
                    ilm_pkg::ACT_INIT:
                    begin
                        src_next   = ent_rst;
                        list_we    = 1'b1;
                        list_wdata = ent_rst;
                    end

                    ilm_pkg::ACT_FILL:
                    begin
                        if (fill_len_reg == '0)
                        begin
                            src_next   = ent_rst;
                            list_we    = 1'b1;
                            list_wdata = ent_rst;
                        end
                        else
                        begin
                            ent_v.head = '0;
                            ent_v.tail = PTR_W'(fill_len_reg) - 1'b1;
                            ent_v.len  = fill_len_reg;
                            src_next   = ent_v;
                            cur_next   = '0;
                            state_next = S_FILL;
                        end
                    end

                    ilm_pkg::ACT_PULL:
                    begin
                        if (list_e.head == NIL)
                        begin
                            status_next = ilm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cur_next   = list_e.head;
                            sout_next  = ilm_pkg::SLOT_W'(list_e.head);
                            state_next = S_PULL;
                        end
                    end

                    ilm_pkg::ACT_APPEND:
                    begin
                        if (slot_bad_reg)
                        begin
                            status_next = ilm_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            tgt_next     = list_e;
                            rep_tgt_next = 1'b1;
                            state_next   = S_APP;
                        end
                    end

                    ilm_pkg::ACT_PREPEND:
                    begin
                        if (slot_bad_reg)
                        begin
                            status_next = ilm_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            ent_v      = list_e;
                            link_we    = 1'b1;
                            link_waddr = slot_ptr[ADDR_W-1:0];
                            if (list_e.head != NIL)
                            begin
                                link_wdata = list_e.head;
                            end
                            else
                            begin
                                link_wdata = NIL;
                                ent_v.tail = slot_ptr;
                            end
                            ent_v.head   = slot_ptr;
                            ent_v.len    = ilm_pkg::len_inc(list_e.len);
                            list_we      = 1'b1;
                            list_wdata   = ent_v;
                            tgt_next     = ent_v;
                            rep_tgt_next = 1'b1;
                        end
                    end

                    ilm_pkg::ACT_FREE:
                    begin
                        if (slot_bad_reg || dst_bad_reg)
                        begin
                            status_next = ilm_pkg::ST_NOT_FOUND;
                        end
                        else if (list_e.head == NIL)
                        begin
                            status_next = ilm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cur_next    = list_e.head;
                            prev_next   = NIL;
                            walk_k_next = '0;
                            state_next  = S_WALK;
                        end
                    end

                    default:
                    begin
                        // unknown action just reports the list
                    end
                endcase
            end

            S_FILL:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg[ADDR_W-1:0];
                if (cur_reg == src_reg.tail)
                begin
                    link_wdata = NIL;
                    list_we    = 1'b1;
                    list_wdata = src_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    link_wdata = cur_reg + 1'b1;
                    cur_next   = cur_reg + 1'b1;
                end
            end

            S_PULL:
            begin
                ent_v.head = link_rdata;
                if (link_rdata == NIL)
                begin
                    ent_v.tail = NIL;
                end
                ent_v.len  = ilm_pkg::len_dec(src_reg.len);
                src_next   = ent_v;
                link_we    = 1'b1;
                link_waddr = cur_reg[ADDR_W-1:0];
                link_wdata = NIL;
                list_we    = 1'b1;
                list_wdata = ent_v;
                state_next = S_DONE;
            end

            S_WALK:
            begin
                if (cur_reg == slot_ptr)
                begin
                    // unlink from the source, then append to the destination
                    if (slot_ptr == src_reg.tail)
                    begin
                        nxt_v      = NIL;
                        ent_v.tail = prev_reg;
                    end
                    if (prev_reg == NIL)
                    begin
                        ent_v.head = nxt_v;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[ADDR_W-1:0];
                        link_wdata = nxt_v;
                    end
                    if (ent_v.head == NIL)
                    begin
                        ent_v.tail = NIL;
                    end
                    ent_v.len  = ilm_pkg::len_dec(src_reg.len);
                    src_next   = ent_v;
                    list_we    = 1'b1;
                    list_wdata = ent_v;
                    state_next = S_DST;
                end
                else if ((link_rdata == NIL) || (walk_k_reg == ilm_pkg::WALK_LAST))
                begin
                    status_next = ilm_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_next   = cur_reg;
                    cur_next    = link_rdata;
                    walk_k_next = walk_k_reg + 1'b1;
                end
            end

            S_DST:
            begin
                // same list: the ram word was read while being rewritten
                tgt_next     = dst_same_reg ? src_reg : dst_e;
                rep_tgt_next = dst_same_reg;
                state_next   = S_APP;
            end

            S_APP:
            begin
                ent_v = tgt_reg;
                if (tgt_reg.tail != NIL)
                begin
                    link_we    = 1'b1;
                    link_waddr = tgt_reg.tail[ADDR_W-1:0];
                    link_wdata = slot_ptr;
                end
                else
                begin
                    ent_v.head = slot_ptr;
                end
                ent_v.tail = slot_ptr;
                ent_v.len  = ilm_pkg::len_inc(tgt_reg.len);
                tgt_next   = ent_v;
                state_next = S_APP_END;
            end

            S_APP_END:
            begin
                link_we    = 1'b1;
                link_waddr = slot_ptr[ADDR_W-1:0];
                link_wdata = NIL;
                list_we    = 1'b1;
                list_waddr = (act_reg == ilm_pkg::ACT_FREE) ? didx_reg : lidx_reg;
                list_wdata = tgt_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{status:      status_reg,
                                       slot_out:    sout_reg,
                                       list_empty:  rep_e.head == NIL,
                                       list_length: rep_e.len};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (list_we)
        begin
            list_vld_next[list_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_vld_reg  <= list_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        lidx_reg     <= lidx_next;
        didx_reg     <= didx_next;
        slot_reg     <= slot_next;
        sout_reg     <= sout_next;
        slot_bad_reg <= slot_bad_next;
        dst_bad_reg  <= dst_bad_next;
        dst_same_reg <= dst_same_next;
        fill_len_reg <= fill_len_next;
        status_reg   <= status_next;
        rep_tgt_reg  <= rep_tgt_next;
        src_reg      <= src_next;
        tgt_reg      <= tgt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        walk_k_reg   <= walk_k_next;
        out_data_reg <= out_data_next;
    end

    // a finished result waits while the output register is held
    `ILM_ASSERT_NXT(a_done_holds, clk, rst_n, (state_reg == S_DONE) && out_valid_reg && !res.ready, (state_reg == S_DONE) && out_valid_reg)

    // the walk never runs past its node limit
    `ILM_ASSERT_IMP(a_walk_bound, clk, rst_n, state_reg == S_WALK, walk_k_reg <= ilm_pkg::WALK_LAST)

    // an accepted beat always starts work
    `ILM_ASSERT_NXT(a_accept_busy, clk, rst_n, cmd.valid && cmd.ready, state_reg != S_IDLE)

endmodule

FILE: hdl/ilm_ram.sv
// ----------------------------------------------------------------------------
// ilm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ilm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: test/indexed_linked_list_manager_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_manager_core_tb
// drives list actions through the cmd channel and keeps its own copy of heads,
// tails, lengths and links; every res beat is checked field by field against
// the oldest predicted result, under random idling on both sides
// ----------------------------------------------------------------------------
module indexed_linked_list_manager_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;
    localparam int LISTS = 4;
    localparam logic [8:0] NO_SLOT = 9'd256;
    localparam int NODE_VISIT_MAX = 2002;
    localparam logic [ilm_pkg::ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ilm_pkg::ACT_W-1:0] ACT_UNUSED_7 = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int EPISODE_OPS = 25;

    logic clk = 1'b0;
    logic rst_n;

    ilm_chan_if #(.T(ilm_pkg::in_item_t))  cmd_if ();
    ilm_chan_if #(.T(ilm_pkg::out_item_t)) res_if ();

    indexed_linked_list_manager_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // local copy of the list state
    logic [8:0]                head_q [LISTS];
    logic [8:0]                tail_q [LISTS];
    logic [ilm_pkg::LEN_W-1:0] len_q  [LISTS];
    logic [8:0]                link_q [SLOTS];
    bit                        slot_used [SLOTS];

    ilm_pkg::out_item_t pending_results [$];

    int send_idle_pct = 29;
    int recv_idle_pct = 56;
    int error_count = 0;
    int checked_count = 0;
    int action_count [8];
    int stall_request = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 checked_count, what, got, want);
        error_count++;
    endtask

    function automatic logic [ilm_pkg::LEN_W-1:0] sat_up(logic [ilm_pkg::LEN_W-1:0] v);
        if (v == ilm_pkg::LEN_MAX)
            return v;
        return v + 1'b1;
    endfunction

    function automatic logic [ilm_pkg::LEN_W-1:0] sat_down(logic [ilm_pkg::LEN_W-1:0] v);
        if (v == '0)
            return v;
        return v - 1'b1;
    endfunction

    function automatic void tail_insert(int l, logic [8:0] s);
        if (tail_q[l] != NO_SLOT)
        begin
            link_q[tail_q[l][7:0]] = s;
            tail_q[l] = s;
        end
        else
        begin
            head_q[l] = s;
            tail_q[l] = s;
        end
        link_q[s[7:0]] = NO_SLOT;
        len_q[l] = sat_up(len_q[l]);
    endfunction

    // walk the source list, unlink s and put it at the tail of dst
    function automatic logic [ilm_pkg::STAT_W-1:0] unlink_and_move(int l, int dst,
                                                                   logic [8:0] s);
        logic [8:0] cur;
        logic [8:0] prev;
        logic [8:0] nxt;
        int k;
        cur = head_q[l];
        prev = NO_SLOT;
        if (cur == NO_SLOT)
            return ilm_pkg::ST_EMPTY;
        for (k = 0; k < NODE_VISIT_MAX && cur != NO_SLOT; k++)
        begin
            nxt = link_q[cur[7:0]];
            if (cur == s)
            begin
                if (s == tail_q[l])
                begin
                    nxt = NO_SLOT;
                    tail_q[l] = prev;
                end
                if (prev == NO_SLOT)
                    head_q[l] = nxt;
                else
                    link_q[prev[7:0]] = nxt;
                if (head_q[l] == NO_SLOT)
                    tail_q[l] = NO_SLOT;
                len_q[l] = sat_down(len_q[l]);
                tail_insert(dst, s);
                return ilm_pkg::ST_OK;
            end
            prev = cur;
            cur = nxt;
        end
        return ilm_pkg::ST_NOT_FOUND;
    endfunction

    function automatic ilm_pkg::out_item_t predict_step(ilm_pkg::in_item_t it);
        ilm_pkg::out_item_t r;
        int l;
        int n;
        int i;
        logic [8:0] s;
        logic [8:0] h;
        l = int'(it.list_id);
        s = {1'b0, it.slot};
        r.status = ilm_pkg::ST_OK;
        r.slot_out = it.slot;
        case (it.action)
            ilm_pkg::ACT_INIT:
            begin
                head_q[l] = NO_SLOT;
                tail_q[l] = NO_SLOT;
                len_q[l] = '0;
            end
            ilm_pkg::ACT_FILL:
            begin
                n = (int'(it.count) > SLOTS) ? SLOTS : int'(it.count);
                if (n == 0)
                begin
                    head_q[l] = NO_SLOT;
                    tail_q[l] = NO_SLOT;
                    len_q[l] = '0;
                end
                else
                begin
                    for (i = 0; i < n - 1; i++)
                        link_q[i] = 9'(i + 1);
                    link_q[n-1] = NO_SLOT;
                    head_q[l] = 9'd0;
                    tail_q[l] = 9'(n - 1);
                    len_q[l] = ilm_pkg::LEN_W'(n);
                end
            end
            ilm_pkg::ACT_PULL:
            begin
                if (head_q[l] == NO_SLOT)
                    r.status = ilm_pkg::ST_EMPTY;
                else
                begin
                    h = head_q[l];
                    len_q[l] = sat_down(len_q[l]);
                    r.slot_out = h[7:0];
                    head_q[l] = link_q[h[7:0]];
                    if (head_q[l] == NO_SLOT)
                        tail_q[l] = NO_SLOT;
                    link_q[h[7:0]] = NO_SLOT;
                end
            end
            ilm_pkg::ACT_APPEND:
                tail_insert(l, s);
            ilm_pkg::ACT_PREPEND:
            begin
                if (head_q[l] != NO_SLOT)
                begin
                    link_q[s[7:0]] = head_q[l];
                    head_q[l] = s;
                end
                else
                begin
                    head_q[l] = s;
                    tail_q[l] = s;
                    link_q[s[7:0]] = NO_SLOT;
                end
                len_q[l] = sat_up(len_q[l]);
            end
            ilm_pkg::ACT_FREE:
                r.status = unlink_and_move(l, int'(it.other_list), s);
            default:
            begin
            end
        endcase
        r.list_empty = (head_q[l] == NO_SLOT);
        r.list_length = len_q[l];
        return r;
    endfunction

    function automatic ilm_pkg::in_item_t cmd_item(logic [ilm_pkg::ACT_W-1:0] act, int lst,
                                                   int oth, int slt, int cnt);
        ilm_pkg::in_item_t it;
        it.action = act;
        it.list_id = ilm_pkg::LID_W'(lst);
        it.other_list = ilm_pkg::LID_W'(oth);
        it.slot = ilm_pkg::SLOT_W'(slt);
        it.count = ilm_pkg::CNT_W'(cnt);
        return it;
    endfunction

    // slots reachable from any head, plus every tail
    function automatic void mark_used_slots();
        logic [8:0] cur;
        int l;
        int k;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        for (l = 0; l < LISTS; l++)
        begin
            cur = head_q[l];
            for (k = 0; k < SLOTS + 4 && cur != NO_SLOT; k++)
            begin
                slot_used[cur[7:0]] = 1'b1;
                cur = link_q[cur[7:0]];
            end
            if (tail_q[l] != NO_SLOT)
                slot_used[tail_q[l][7:0]] = 1'b1;
        end
    endfunction

    // mostly well-formed actions on disjoint lists, some raw noise
    function automatic ilm_pkg::in_item_t next_random_item();
        ilm_pkg::in_item_t it;
        int pick;
        int l;
        int k;
        int pool [$];
        logic [8:0] cur;
        l = $urandom_range(LISTS - 1);
        pick = $urandom_range(99);
        it.list_id = ilm_pkg::LID_W'(l);
        it.other_list = ilm_pkg::LID_W'($urandom_range(LISTS - 1));
        it.slot = ilm_pkg::SLOT_W'($urandom_range(SLOTS - 1));
        it.count = ($urandom_range(9) == 0) ? ilm_pkg::CNT_W'($urandom_range(511))
                                            : ilm_pkg::CNT_W'($urandom_range(40));
        if (pick < 15)
            it.action = ilm_pkg::ACT_W'($urandom_range(ACT_UNUSED_7));
        else if (pick < 35)
            it.action = ilm_pkg::ACT_PULL;
        else if (pick < 70)
        begin
            it.action = $urandom_range(1) ? ilm_pkg::ACT_APPEND : ilm_pkg::ACT_PREPEND;
            mark_used_slots();
            foreach (slot_used[i])
                if (!slot_used[i])
                    pool.push_back(i);
            if (pool.size() != 0)
                it.slot = ilm_pkg::SLOT_W'(pool[$urandom_range(pool.size() - 1)]);
        end
        else
        begin
            it.action = ilm_pkg::ACT_FREE;
            cur = head_q[l];
            for (k = 0; k < SLOTS && cur != NO_SLOT; k++)
            begin
                pool.push_back(int'(cur));
                cur = link_q[cur[7:0]];
            end
            if (pool.size() != 0)
                it.slot = ilm_pkg::SLOT_W'(pool[$urandom_range(pool.size() - 1)]);
        end
        return it;
    endfunction

    task automatic send_cmd(ilm_pkg::in_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= it;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        action_count[it.action]++;
        pending_results.push_back(predict_step(it));
    endtask

    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_actions();
        send_cmd(cmd_item(ilm_pkg::ACT_INIT, 0, 0, 0, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_PULL, 0, 0, 0, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 0, 1, 5, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 0, 0, 0, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 1, 0, 0, 511));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 3, 0, 0, 300));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 0, 0, 0, 3));
        send_cmd(cmd_item(ilm_pkg::ACT_APPEND, 2, 0, 255, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_PREPEND, 2, 0, 128, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_APPEND, 2, 0, 64, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_INIT, 3, 0, 0, 0));
        // tail, then head into its own list, then a miss
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 2, 3, 64, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 2, 2, 128, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 2, 3, 7, 0));
        // single node list: head and tail at once
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 3, 0, 64, 0));
        send_cmd(cmd_item(ACT_UNUSED_6, 3, 0, 9, 0));
        send_cmd(cmd_item(ACT_UNUSED_7, 2, 3, 250, 257));
        repeat (5) send_cmd(cmd_item(ilm_pkg::ACT_PULL, 0, 0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_link_corruption();
        // overlapping fills: pulls run past the recorded length
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 0, 0, 0, 2));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 1, 0, 0, 5));
        repeat (4) send_cmd(cmd_item(ilm_pkg::ACT_PULL, 0, 0, 0, 0));
        // closed loop 3 -> 0 -> 1 -> 2 -> 3, a miss must stop the walk
        send_cmd(cmd_item(ilm_pkg::ACT_INIT, 1, 0, 0, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FILL, 1, 0, 0, 4));
        send_cmd(cmd_item(ilm_pkg::ACT_PREPEND, 1, 0, 3, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 1, 2, 200, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_FREE, 1, 2, 1, 0));
        wait_for_drain();
    endtask

    task automatic test_length_saturation();
        int slt;
        slt = $urandom_range(SLOTS - 1);
        send_cmd(cmd_item(ilm_pkg::ACT_INIT, 2, 0, 0, 0));
        repeat (515) send_cmd(cmd_item(ilm_pkg::ACT_APPEND, 2, 0, slt, 0));
        send_cmd(cmd_item(ilm_pkg::ACT_INIT, 2, 0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        stall_request++;
        repeat (12) send_cmd(next_random_item());
        wait_for_drain();
    endtask

    task automatic test_random_traffic(int n_items);
        int sent;
        int l;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            for (l = 0; l < LISTS; l++)
                send_cmd(cmd_item(ilm_pkg::ACT_INIT, l, 0, 0, 0));
            send_cmd(cmd_item(ilm_pkg::ACT_FILL, $urandom_range(LISTS - 1), 0, 0,
                              $urandom_range(1, 24)));
            for (k = 0; k < EPISODE_OPS; k++)
                send_cmd(next_random_item());
            sent += LISTS + 1 + EPISODE_OPS;
        end
        wait_for_drain();
    endtask

    // result side: check each beat, then drive ready for the next edge
    always @(posedge clk)
    begin : res_side
        ilm_pkg::out_item_t got;
        ilm_pkg::out_item_t want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got = res_if.data;
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing expected, slot_out",
                                int'(got.slot_out), -1);
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.slot_out !== want.slot_out)
                    report_mismatch("slot_out", int'(got.slot_out), int'(want.slot_out));
                if (got.list_empty !== want.list_empty)
                    report_mismatch("list_empty", int'(got.list_empty),
                                    int'(want.list_empty));
                if (got.list_length !== want.list_length)
                    report_mismatch("list_length", int'(got.list_length),
                                    int'(want.list_length));
            end
        end
        if (stall_request != stall_seen)
        begin
            stall_seen = stall_request;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        res_if.ready = 1'b0;
        foreach (action_count[i])
            action_count[i] = 0;
        for (int l = 0; l < LISTS; l++)
        begin
            head_q[l] = NO_SLOT;
            tail_q[l] = NO_SLOT;
            len_q[l] = '0;
        end
        foreach (link_q[i])
            link_q[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_actions();
        test_link_corruption();
        test_random_traffic(300);

        send_idle_pct = 56;
        recv_idle_pct = 29;
        test_length_saturation();
        test_backpressure();
        test_random_traffic(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("actions sent: init %0d, fill %0d, pull %0d, append %0d, prepend %0d, free %0d",
                 action_count[ilm_pkg::ACT_INIT], action_count[ilm_pkg::ACT_FILL],
                 action_count[ilm_pkg::ACT_PULL], action_count[ilm_pkg::ACT_APPEND],
                 action_count[ilm_pkg::ACT_PREPEND], action_count[ilm_pkg::ACT_FREE]);
        $display("unused codes %0d, results checked %0d, mismatches %0d",
                 action_count[ACT_UNUSED_6] + action_count[ACT_UNUSED_7],
                 checked_count, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
